// File: design/etc_pkg.sv
// Shared types and constants for the Euler trail check block.
// Used by eulerian_trail_check and its port checker; depends on nothing.
`timescale 1ns / 1ps

package etc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VID_W        = 6;
  localparam int CNT_W        = 7;

  typedef logic [MAX_VERTICES-1:0] vset_t;
  typedef logic [VID_W-1:0]        vid_t;
  typedef logic [CNT_W-1:0]        vcnt_t;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_LOAD_A     = 10'b00_0000_0010,
    ST_LOAD_B     = 10'b00_0000_0100,
    ST_EV_ROOT    = 10'b00_0000_1000,
    ST_EV_ODD1    = 10'b00_0001_0000,
    ST_EV_ODD2    = 10'b00_0010_0000,
    ST_EV_ODD3    = 10'b00_0100_0000,
    ST_WALK_PICK  = 10'b00_1000_0000,
    ST_WALK_MERGE = 10'b01_0000_0000,
    ST_DONE       = 10'b10_0000_0000
  } state_e;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic vid_t find_first(input vset_t v);
    vid_t idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) idx = VID_W'(i);
    end
    return idx;
  endfunction

  function automatic vset_t one_hot(input vid_t idx);
    vset_t v;
    v = vset_t'(1) << idx;
    return v;
  endfunction

endpackage

// File: design/eulerian_trail_check.sv
// Euler trail existence check: edge loading, odd-vertex scan and reachability walk.
// Depends on etc_pkg (types, state codes, find_first and one_hot helpers).
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | kind_i, edge_from_i, edge_to_i
//  out     | source    | out_valid_o / out_stall_i| is_eulerian_o, closed_trail_o,
//          |           |                        | open_trail_o, trail_start_o, trail_end_o
//  cfg     | sink      | cfg_we_i               | cfg_wdata_i (vertex_count)
//
// An edge beat reads both adjacency rows in its accept cycle, then each row gets its
// write through the single write port. An edge with an endpoint out of range is taken
// and dropped. An evaluate beat is accepted, scanned (root, then the odd set), walked
// for connectivity where the odd set allows it, with a pick and a merge step per vertex
// reached, and closed by a last step that loads the result, all through one shared
// lowest-set-bit unit and one memory read port.
// Reset and every evaluate clear the store at once through per-row valid bits.
// A result waits in the output register; edges are still taken meanwhile, and an
// evaluate holds in its last cycle until the output register is free.

module eulerian_trail_check
  import etc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  vid_t       edge_from_i,
  input  vid_t       edge_to_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_eulerian_o,
  output logic       closed_trail_o,
  output logic       open_trail_o,
  output vid_t       trail_start_o,
  output vid_t       trail_end_o
);

  state_e state_q, state_d;
  vcnt_t  cfg_q;
  vset_t  parity_q, parity_d;
  vset_t  active_q, active_d;
  vset_t  row_vld_q, row_vld_d;
  vset_t  reached_q, reached_d;
  vset_t  scan_q, scan_d;
  vid_t   ea_q, ea_d, eb_q, eb_d;
  vid_t   root_q, root_d, first_q, first_d, second_q, second_d;
  vid_t   start_q, start_d, end_q, end_d;
  logic   two_odd_q, two_odd_d;
  logic   euler_q, euler_d, closed_q, closed_d, open_q, open_d;
  logic   out_vld_q, out_vld_d;
  logic   out_eul_q, out_clo_q, out_opn_q;
  vid_t   out_start_q, out_end_q;
  logic   out_load;

  vset_t  adj_mem [MAX_VERTICES];
  vset_t  rd_a_q, rd_b_q;
  logic   rdv_a_q, rdv_b_q;
  vid_t   rd_addr_a;
  vid_t   rd_addr_b;
  logic   mem_we;
  vid_t   mem_waddr;
  vset_t  mem_wdata;

  vcnt_t  n_eff;
  vset_t  mask, act, odd, row_a, row_b, nb;
  vid_t   ff_idx;
  logic   in_acc, in_range;

  always_comb begin
    n_eff = (cfg_q > vcnt_t'(MAX_VERTICES)) ? vcnt_t'(MAX_VERTICES) : cfg_q;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = vcnt_t'(i) < n_eff;
    end
  end

  assign act      = active_q & mask;
  assign odd      = parity_q & act;
  assign ff_idx   = find_first(scan_q);
  assign row_a    = rdv_a_q ? rd_a_q : '0;
  assign row_b    = rdv_b_q ? rd_b_q : '0;
  assign nb       = row_a & mask & ~reached_q;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_range = ({1'b0, edge_from_i} < n_eff) && ({1'b0, edge_to_i} < n_eff);
  assign rd_addr_a = (state_q == ST_WALK_PICK) ? ff_idx : edge_from_i;
  // Once the beat is taken the input may move on, so the second row follows the latch.
  assign rd_addr_b = (state_q == ST_IDLE) ? edge_to_i : eb_q;

  always_comb begin
    state_d   = state_q;
    parity_d  = parity_q;
    active_d  = active_q;
    row_vld_d = row_vld_q;
    reached_d = reached_q;
    scan_d    = scan_q;
    ea_d      = ea_q;
    eb_d      = eb_q;
    root_d    = root_q;
    first_d   = first_q;
    second_d  = second_q;
    start_d   = start_q;
    end_d     = end_q;
    two_odd_d = two_odd_q;
    euler_d   = euler_q;
    closed_d  = closed_q;
    open_d    = open_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ea_q;
    mem_wdata = row_a | one_hot(eb_q);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_EVAL) begin
            scan_d   = act;
            euler_d  = 1'b0;
            closed_d = 1'b0;
            open_d   = 1'b0;
            state_d  = ST_EV_ROOT;
          end else if (in_range) begin
            // A self-loop adds two to the degree, so parity stays put.
            parity_d = parity_q ^ (one_hot(edge_from_i) ^ one_hot(edge_to_i));
            active_d = active_q | one_hot(edge_from_i) | one_hot(edge_to_i);
            ea_d     = edge_from_i;
            eb_d     = edge_to_i;
            state_d  = ST_LOAD_A;
          end
        end
      end
      ST_LOAD_A: begin
        mem_we          = 1'b1;
        row_vld_d[ea_q] = 1'b1;
        state_d         = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        mem_we          = 1'b1;
        mem_waddr       = eb_q;
        mem_wdata       = row_b | one_hot(ea_q);
        row_vld_d[eb_q] = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_EV_ROOT: begin
        if (scan_q == '0) begin
          start_d = '0;
          end_d   = '0;
          state_d = ST_DONE;
        end else begin
          root_d  = ff_idx;
          start_d = ff_idx;
          end_d   = ff_idx;
          scan_d  = odd;
          state_d = ST_EV_ODD1;
        end
      end
      ST_EV_ODD1: begin
        if (scan_q == '0) begin
          two_odd_d = 1'b0;
          reached_d = one_hot(root_q);
          scan_d    = one_hot(root_q);
          state_d   = ST_WALK_PICK;
        end else begin
          first_d = ff_idx;
          scan_d  = scan_q & ~one_hot(ff_idx);
          state_d = ST_EV_ODD2;
        end
      end
      ST_EV_ODD2: begin
        if (scan_q == '0) begin
          state_d = ST_DONE;
        end else begin
          second_d = ff_idx;
          scan_d   = scan_q & ~one_hot(ff_idx);
          state_d  = ST_EV_ODD3;
        end
      end
      ST_EV_ODD3: begin
        if (scan_q != '0) begin
          state_d = ST_DONE;
        end else begin
          start_d   = first_q;
          end_d     = second_q;
          two_odd_d = 1'b1;
          reached_d = one_hot(root_q);
          scan_d    = one_hot(root_q);
          state_d   = ST_WALK_PICK;
        end
      end
      ST_WALK_PICK: begin
        // The pending set is a work list; its lowest member has its row read now.
        if (scan_q == '0) begin
          euler_d  = (act & ~reached_q) == '0;
          closed_d = ((act & ~reached_q) == '0) && !two_odd_q;
          open_d   = ((act & ~reached_q) == '0) && two_odd_q;
          state_d  = ST_DONE;
        end else begin
          scan_d  = scan_q & ~one_hot(ff_idx);
          state_d = ST_WALK_MERGE;
        end
      end
      ST_WALK_MERGE: begin
        reached_d = reached_q | nb;
        scan_d    = scan_q | nb;
        state_d   = ST_WALK_PICK;
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          parity_d  = '0;
          active_d  = '0;
          row_vld_d = '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= vcnt_t'(MAX_VERTICES);
      parity_q  <= '0;
      active_q  <= '0;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      parity_q  <= parity_d;
      active_q  <= active_d;
      row_vld_q <= row_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reached_q <= reached_d;
    scan_q    <= scan_d;
    ea_q      <= ea_d;
    eb_q      <= eb_d;
    root_q    <= root_d;
    first_q   <= first_d;
    second_q  <= second_d;
    start_q   <= start_d;
    end_q     <= end_d;
    two_odd_q <= two_odd_d;
    euler_q   <= euler_d;
    closed_q  <= closed_d;
    open_q    <= open_d;
    if (out_load) begin
      out_eul_q   <= euler_q;
      out_clo_q   <= closed_q;
      out_opn_q   <= open_q;
      out_start_q <= start_q;
      out_end_q   <= end_q;
    end
  end

  // Adjacency rows: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) adj_mem[mem_waddr] <= mem_wdata;
    rd_a_q  <= adj_mem[rd_addr_a];
    rd_b_q  <= adj_mem[rd_addr_b];
    rdv_a_q <= row_vld_q[rd_addr_a];
    rdv_b_q <= row_vld_q[rd_addr_b];
  end

  assign out_valid_o    = out_vld_q;
  assign is_eulerian_o  = out_eul_q;
  assign closed_trail_o = out_clo_q;
  assign open_trail_o   = out_opn_q;
  assign trail_start_o  = out_start_q;
  assign trail_end_o    = out_end_q;

endmodule

// File: design/etc_checker.sv
// Port-level checker for eulerian_trail_check, attached by the bind at the end.
// Depends on etc_pkg for the vertex id type.
`timescale 1ns / 1ps

module etc_checker
  import etc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic is_eulerian_o,
  input logic closed_trail_o,
  input logic open_trail_o,
  input vid_t trail_start_o,
  input vid_t trail_end_o
);

  // A result beat that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A circuit and an open trail exclude each other.
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(closed_trail_o && open_trail_o))
    else $error("closed and open trail both reported");

  // The Euler flag is exactly the union of the two trail kinds.
  a_euler_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_eulerian_o == (closed_trail_o || open_trail_o)))
    else $error("Euler flag disagrees with trail kind");

  // An open trail runs from the lower odd vertex to the higher one.
  a_open_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_trail_o |-> (trail_start_o < trail_end_o))
    else $error("open trail ends out of order");

endmodule

bind eulerian_trail_check etc_checker u_etc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .is_eulerian_o  (is_eulerian_o),
  .closed_trail_o (closed_trail_o),
  .open_trail_o   (open_trail_o),
  .trail_start_o  (trail_start_o),
  .trail_end_o    (trail_end_o)
);
